// ===== hdl/ofn_pkg.sv =====
// ----------------------------------------------------------------------------
// ofn_pkg
// Shared types and fixed widths for the oriented face normal core.
// ----------------------------------------------------------------------------
package ofn_pkg;

  // Store word: Q11.12 position and Q1.14 vertex normal
  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } vertex_t;

  localparam int A_W        = 30;          // normalized magnitude, leading one at bit 29
  localparam int A_TOP      = 29;
  localparam int NSQ_W      = 62;          // sum of three squares of A_W values
  localparam int ROOT_W     = 31;          // floor(sqrt) of NSQ_W value
  localparam int SQRT_STEPS = 32;          // one root bit per stage
  localparam int Q_W        = 16;          // quotient width
  localparam int NUM_W      = 46;          // a * 2^14 + r / 2
  localparam int FRAC_W     = 14;
  localparam logic [Q_W-1:0] UNIT = 16'd16384;

  // Per-triangle control carried down the pipeline
  typedef struct packed {
    logic [2:0] neg;     // component sign after orientation
    logic       flip;
    logic       degen;
    logic       last;
  } side_t;

  // Tag carried alongside the square root
  typedef struct packed {
    logic [2:0][A_W-1:0] a;
    side_t               side;
  } sq_tag_t;

endpackage

// ===== hdl/ofn_sqrt.sv =====
// ----------------------------------------------------------------------------
// ofn_sqrt
// Pipelined integer square root, one result bit per stage, with a tag.
// ----------------------------------------------------------------------------
module ofn_sqrt #(
  parameter int TW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ofn_pkg::NSQ_W-1:0] in_n,
  input  logic [TW-1:0]             in_tag,
  output logic                      out_valid,
  output logic [ofn_pkg::ROOT_W-1:0] out_root,
  output logic [TW-1:0]             out_tag
);

  localparam int STEPS = ofn_pkg::SQRT_STEPS;

  logic        v   [STEPS+1];
  logic [63:0] rem [STEPS+1];
  logic [63:0] rt  [STEPS+1];
  logic [TW-1:0] tg [STEPS+1];

  assign v[0]   = in_valid;
  assign rem[0] = 64'(in_n);
  assign rt[0]  = '0;
  assign tg[0]  = in_tag;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (2 * (STEPS - 1 - k));
    logic [63:0] trial;
    assign trial = rt[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tg[k+1] <= tg[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          rt[k+1]  <= (rt[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          rt[k+1]  <= rt[k] >> 1;
        end
      end
    end
  end

  assign out_valid = v[STEPS];
  assign out_root  = rt[STEPS][ofn_pkg::ROOT_W-1:0];
  assign out_tag   = tg[STEPS];

endmodule

// ===== hdl/ofn_div.sv =====
// ----------------------------------------------------------------------------
// ofn_div
// Three-lane pipelined restoring divider: q = (a * 2^14 + r / 2) / r.
// ----------------------------------------------------------------------------
module ofn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0][ofn_pkg::A_W-1:0] in_a,
  input  logic [ofn_pkg::ROOT_W-1:0]  in_root,
  input  ofn_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [2:0][ofn_pkg::Q_W-1:0] out_q,
  output ofn_pkg::side_t              out_side
);

  localparam int STEPS = ofn_pkg::Q_W;
  localparam int NW    = ofn_pkg::NUM_W;

  logic                         v   [STEPS+1];
  logic [2:0][NW-1:0]           rem [STEPS+1];
  logic [2:0][ofn_pkg::Q_W-1:0] q   [STEPS+1];
  logic [ofn_pkg::ROOT_W-1:0]   dv  [STEPS+1];
  ofn_pkg::side_t               sd  [STEPS+1];

  assign v[0]  = in_valid;
  assign dv[0] = in_root;
  assign sd[0] = in_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = NW'({in_a[i], {ofn_pkg::FRAC_W{1'b0}}}) + NW'(in_root >> 1);
      q[0][i]   = '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int J = STEPS - 1 - k;
    logic [NW:0] dsh;
    assign dsh = (NW + 1)'(dv[k]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
        for (int i = 0; i < 3; i++) begin
          if ((NW + 1)'(rem[k][i]) >= dsh) begin
            rem[k+1][i] <= NW'((NW + 1)'(rem[k][i]) - dsh);
            q[k+1][i]   <= q[k][i] | (ofn_pkg::Q_W'(1) << J);
          end else begin
            rem[k+1][i] <= rem[k][i];
            q[k+1][i]   <= q[k][i];
          end
        end
      end
    end
  end

  assign out_valid = v[STEPS];
  assign out_q     = q[STEPS];
  assign out_side  = sd[STEPS];

endmodule

// ===== hdl/oriented_face_normal_core.sv =====
// ----------------------------------------------------------------------------
// oriented_face_normal_core
// Vertex store plus oriented, normalized triangle face normal pipeline.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Handshake           | Carries
// --------+-----------+---------------------+------------------------------------
// in      | in        | in_valid / in_ready | mode, vertex, corners, last_in
// out     | out       | out_valid/out_ready | face_x/y/z, flipped, degenerate,
//         |           |                     | last_out
//
// A load transaction is written to the store when accepted; a triangle
// transaction reads its corners in turn through the vertex store's single port.
// After a triangle is accepted, its result passes two more corner reads,
// 10 arithmetic stages, 32 square root stages, 16 divide stages and the
// output register before out_valid rises.
// Reset clears all valid bits and the read sequencer; the store is not
// cleared. The whole pipeline, store read included, holds while a result
// waits at the output and out_ready is low.
//
module oriented_face_normal_core #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [11:0]        vertex_index,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [15:0] vnorm_x,
  input  logic signed [15:0] vnorm_y,
  input  logic signed [15:0] vnorm_z,
  input  logic [11:0]        corner_a,
  input  logic [11:0]        corner_b,
  input  logic [11:0]        corner_c,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] face_x,
  output logic signed [15:0] face_y,
  output logic signed [15:0] face_z,
  output logic               flipped,
  output logic               degenerate,
  output logic               last_out
);

  localparam int IW = $clog2(VERTEX_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(VERTEX_DEPTH);

  // Global advance: everything moves unless a result is stuck at the output
  logic en;
  assign en = !out_valid || out_ready;

  // --------------------------------------------------------------------------
  // Read sequencer and vertex store
  // --------------------------------------------------------------------------
  logic          busy, ph;
  logic [IW-1:0] seq_b, seq_c;
  logic          seq_bz, seq_cz, seq_last;
  logic          in_acc, load_acc, tri_acc;
  logic          a_ok, b_ok, c_ok, w_ok;

  assign in_ready = en && !busy;
  assign in_acc   = in_valid && in_ready;
  assign load_acc = in_acc && !mode;
  assign tri_acc  = in_acc && mode;

  assign w_ok = {5'd0, vertex_index} < DEPTH17;
  assign a_ok = {5'd0, corner_a} < DEPTH17;
  assign b_ok = {5'd0, corner_b} < DEPTH17;
  assign c_ok = {5'd0, corner_c} < DEPTH17;

  logic            mem_we, rd_issue, rd_issue_z, rd_issue_third;
  logic [IW-1:0]   mem_addr;
  ofn_pkg::vertex_t wr_vtx;

  always_comb begin
    if (busy) begin
      mem_addr   = ph ? seq_c : seq_b;
      rd_issue_z = ph ? seq_cz : seq_bz;
    end else if (mode) begin
      mem_addr   = IW'(corner_a);
      rd_issue_z = !a_ok;
    end else begin
      mem_addr   = IW'(vertex_index);
      rd_issue_z = 1'b0;
    end
  end

  assign rd_issue       = busy || tri_acc;
  assign rd_issue_third = busy && ph;
  assign mem_we         = load_acc && w_ok;
  assign wr_vtx         = '{px: pos_x, py: pos_y, pz: pos_z,
                            nx: vnorm_x, ny: vnorm_y, nz: vnorm_z};

  ofn_pkg::vertex_t mem [VERTEX_DEPTH];
  ofn_pkg::vertex_t rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_vtx;
    end
    if (en) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= 1'b0;
    end else if (en) begin
      if (busy) begin
        ph   <= !ph;
        busy <= !ph;
      end else if (tri_acc) begin
        busy <= 1'b1;
        ph   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tri_acc) begin
      seq_b    <= IW'(corner_b);
      seq_c    <= IW'(corner_c);
      seq_bz   <= !b_ok;
      seq_cz   <= !c_ok;
      seq_last <= last_in;
    end
  end

  // Read tags line up with rd_data
  logic rd_val, rd_third, rd_zero, rd_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_val <= 1'b0;
    end else if (en) begin
      rd_val <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_third <= rd_issue_third;
      rd_zero  <= rd_issue_z;
      rd_last  <= seq_last;
    end
  end

  // Corners beyond the depth read as zero
  ofn_pkg::vertex_t v_eff, va, vb;
  assign v_eff = rd_zero ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (en && rd_val && !rd_third) begin
      vb <= v_eff;
      va <= vb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: edges and vertex normal sum (p0 = va, p1 = vb, p2 = v_eff)
  // --------------------------------------------------------------------------
  logic               s1_v, s1_last;
  logic signed [24:0] s1_e1 [3];
  logic signed [24:0] s1_e2 [3];
  logic signed [17:0] s1_s  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= rd_val && rd_third;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last  <= rd_last;
      s1_e1[0] <= vb.px - va.px;
      s1_e1[1] <= vb.py - va.py;
      s1_e1[2] <= vb.pz - va.pz;
      s1_e2[0] <= v_eff.px - va.px;
      s1_e2[1] <= v_eff.py - va.py;
      s1_e2[2] <= v_eff.pz - va.pz;
      s1_s[0]  <= va.nx + vb.nx + v_eff.nx;
      s1_s[1]  <= va.ny + vb.ny + v_eff.ny;
      s1_s[2]  <= va.nz + vb.nz + v_eff.nz;
    end
  end

  // Stage 2: the six cross product terms
  logic               s2_v, s2_last;
  logic signed [49:0] s2_m [6];
  logic signed [17:0] s2_s [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last <= s1_last;
      s2_s    <= s1_s;
      s2_m[0] <= s1_e1[1] * s1_e2[2];
      s2_m[1] <= s1_e1[2] * s1_e2[1];
      s2_m[2] <= s1_e1[2] * s1_e2[0];
      s2_m[3] <= s1_e1[0] * s1_e2[2];
      s2_m[4] <= s1_e1[0] * s1_e2[1];
      s2_m[5] <= s1_e1[1] * s1_e2[0];
    end
  end

  // Stage 3: cross product
  logic               s3_v, s3_last;
  logic signed [50:0] s3_c [3];
  logic signed [17:0] s3_s [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_last;
      s3_s    <= s2_s;
      s3_c[0] <= s2_m[0] - s2_m[1];
      s3_c[1] <= s2_m[2] - s2_m[3];
      s3_c[2] <= s2_m[4] - s2_m[5];
    end
  end

  // Stage 4: dot product partial products (c split at bit 24), magnitudes
  logic               s4_v;
  logic signed [44:0] s4_ph [3];
  logic signed [42:0] s4_pl [3];
  logic [50:0]        s4_mag [3];
  ofn_pkg::side_t     s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_ph[i]  <= $signed(s3_c[i][50:24]) * s3_s[i];
        s4_pl[i]  <= $signed({1'b0, s3_c[i][23:0]}) * s3_s[i];
        s4_mag[i] <= s3_c[i][50] ? 51'(-s3_c[i]) : 51'(s3_c[i]);
        s4_side.neg[i] <= s3_c[i][50];
      end
      s4_side.flip  <= 1'b0;
      s4_side.degen <= (s3_c[0] == '0) && (s3_c[1] == '0) && (s3_c[2] == '0);
      s4_side.last  <= s3_last;
    end
  end

  // Stage 5: sums of the partial products, OR of magnitudes for the lead
  logic               s5_v;
  logic signed [46:0] s5_hi;
  logic signed [44:0] s5_lo;
  logic [50:0]        s5_orv;
  logic [50:0]        s5_mag [3];
  ofn_pkg::side_t     s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hi   <= s4_ph[0] + s4_ph[1] + s4_ph[2];
      s5_lo   <= s4_pl[0] + s4_pl[1] + s4_pl[2];
      s5_orv  <= s4_mag[0] | s4_mag[1] | s4_mag[2];
      s5_mag  <= s4_mag;
      s5_side <= s4_side;
    end
  end

  // Stage 6: orientation sign; leading one found per byte
  logic signed [71:0] dot_full;
  logic [55:0]        or_pad;
  logic [6:0]         grp_nz;
  logic [2:0]         grp_pos [7];

  assign dot_full = $signed({s5_hi, 24'd0}) + s5_lo;
  assign or_pad   = 56'(s5_orv);

  always_comb begin
    for (int g = 0; g < 7; g++) begin
      grp_nz[g]  = |or_pad[g*8 +: 8];
      grp_pos[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or_pad[g*8 + b]) begin
          grp_pos[g] = 3'(b);
        end
      end
    end
  end

  logic           s6_v;
  logic [6:0]     s6_nz;
  logic [2:0]     s6_pos [7];
  logic [50:0]    s6_mag [3];
  ofn_pkg::side_t s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_nz         <= grp_nz;
      s6_pos        <= grp_pos;
      s6_mag        <= s5_mag;
      s6_side.neg   <= s5_side.neg ^ {3{dot_full[71]}};
      s6_side.flip  <= dot_full[71];
      s6_side.degen <= s5_side.degen;
      s6_side.last  <= s5_side.last;
    end
  end

  // Stage 7: leading one position of the largest magnitude
  logic [5:0] lead_c;

  always_comb begin
    lead_c = '0;
    for (int g = 0; g < 7; g++) begin
      if (s6_nz[g]) begin
        lead_c = {3'(g), s6_pos[g]};
      end
    end
  end

  logic           s7_v;
  logic [5:0]     s7_lead;
  logic [50:0]    s7_mag [3];
  ofn_pkg::side_t s7_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_lead <= lead_c;
      s7_mag  <= s6_mag;
      s7_side <= s6_side;
    end
  end

  // Stage 8: common shift so that the largest lands in [2^29, 2^30)
  logic [ofn_pkg::A_W-1:0] a_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s7_lead >= 6'(ofn_pkg::A_TOP)) begin
        a_c[i] = ofn_pkg::A_W'(s7_mag[i] >> (s7_lead - 6'(ofn_pkg::A_TOP)));
      end else begin
        a_c[i] = ofn_pkg::A_W'(s7_mag[i] << (6'(ofn_pkg::A_TOP) - s7_lead));
      end
    end
  end

  logic                         s8_v;
  logic [2:0][ofn_pkg::A_W-1:0] s8_a;
  ofn_pkg::side_t               s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s8_a[i] <= a_c[i];
      end
      s8_side <= s7_side;
    end
  end

  // Stage 9: squares; stage 10: their sum
  logic                         s9_v;
  logic [59:0]                  s9_sq [3];
  logic [2:0][ofn_pkg::A_W-1:0] s9_a;
  ofn_pkg::side_t               s9_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s9_sq[i] <= 60'(s8_a[i]) * 60'(s8_a[i]);
      end
      s9_a    <= s8_a;
      s9_side <= s8_side;
    end
  end

  logic                        s10_v;
  logic [ofn_pkg::NSQ_W-1:0]   s10_nsq;
  ofn_pkg::sq_tag_t            s10_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_nsq      <= ofn_pkg::NSQ_W'(s9_sq[0]) + ofn_pkg::NSQ_W'(s9_sq[1])
                    + ofn_pkg::NSQ_W'(s9_sq[2]);
      s10_tag.a    <= s9_a;
      s10_tag.side <= s9_side;
    end
  end

  // --------------------------------------------------------------------------
  // Square root and division
  // --------------------------------------------------------------------------
  logic                       sq_v;
  logic [ofn_pkg::ROOT_W-1:0] sq_root;
  ofn_pkg::sq_tag_t           sq_tag;

  ofn_sqrt #(
    .TW($bits(ofn_pkg::sq_tag_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s10_v),
    .in_n     (s10_nsq),
    .in_tag   (s10_tag),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  logic                         dv_v;
  logic [2:0][ofn_pkg::Q_W-1:0] dv_q;
  ofn_pkg::side_t               dv_side;

  ofn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_v),
    .in_a     (sq_tag.a),
    .in_root  (sq_root),
    .in_side  (sq_tag.side),
    .out_valid(dv_v),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // --------------------------------------------------------------------------
  // Clamp, sign and output register
  // --------------------------------------------------------------------------
  logic [ofn_pkg::Q_W-1:0] comp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [ofn_pkg::Q_W-1:0] u;
      u = (dv_q[i] > ofn_pkg::UNIT) ? ofn_pkg::UNIT : dv_q[i];
      if (dv_side.degen) begin
        comp[i] = '0;
      end else if (dv_side.neg[i]) begin
        comp[i] = -u;
      end else begin
        comp[i] = u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_x     <= $signed(comp[0]);
      face_y     <= $signed(comp[1]);
      face_z     <= $signed(comp[2]);
      flipped    <= dv_side.flip && !dv_side.degen;
      degenerate <= dv_side.degen;
      last_out   <= dv_side.last;
    end
  end

endmodule

// ===== hdl/ofn_checker.sv =====
// ----------------------------------------------------------------------------
// ofn_checker
// Port-level checks for the oriented face normal core.
// ----------------------------------------------------------------------------
module ofn_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] face_x,
  input logic signed [15:0] face_y,
  input logic signed [15:0] face_z,
  input logic               flipped,
  input logic               degenerate
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(face_x) && $stable(face_y)
      && $stable(face_z) && $stable(flipped) && $stable(degenerate))
    else $error("result changed while stalled");

  // A triangle owns the store port while its remaining corners are read
  a_tri_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode |=> !in_ready ##1 !in_ready)
    else $error("ready during corner reads");

  // Degenerate results are all zero and never flipped
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> face_x == 16'sd0 && face_y == 16'sd0
      && face_z == 16'sd0 && !flipped)
    else $error("degenerate result not zero");

  // Unit components stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> face_x >= -16'sd16384 && face_x <= 16'sd16384
      && face_y >= -16'sd16384 && face_y <= 16'sd16384
      && face_z >= -16'sd16384 && face_z <= 16'sd16384)
    else $error("component out of range");

  // Nothing leaves right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind oriented_face_normal_core ofn_checker u_ofn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .face_x    (face_x),
  .face_y    (face_y),
  .face_z    (face_z),
  .flipped   (flipped),
  .degenerate(degenerate)
);

// ===== bench/oriented_face_normal_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_face_normal_core_tb
// Self-checking bench: vertex loads and triangle transactions are pushed
// through the core, and each face normal is checked against a local
// fixed-point predictor.
// ----------------------------------------------------------------------------
module oriented_face_normal_core_tb;

  localparam int DEPTH     = 4096;
  localparam int MAX_CYC   = 400000;
  localparam int DRAIN_CYC = 100;
  localparam bit MODE_LOAD = 1'b0;
  localparam bit MODE_TRI  = 1'b1;

  typedef struct {
    bit               mode;
    logic [11:0]      idx;
    logic signed [23:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [11:0]      ca, cb, cc;
    bit               last;
  } vtx_txn_t;

  typedef struct {
    logic signed [15:0] fx, fy, fz;
    bit                 flip, degen, last;
  } face_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic mode = 1'b0;
  logic [11:0] vertex_index = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] vnorm_x = '0, vnorm_y = '0, vnorm_z = '0;
  logic [11:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic last_in = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic signed [15:0] face_x, face_y, face_z;
  logic flipped, degenerate, last_out;

  oriented_face_normal_core i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Pending transactions, expected faces and the predictor's own store
  vtx_txn_t pending_txns[$];
  vtx_txn_t cur_txn;
  face_t    expected_faces[$];
  ofn_pkg::vertex_t shadow_store[DEPTH];
  bit       slot_written[DEPTH];
  int       loaded_slots[$];

  int err_count = 0, checked_faces = 0, sent_txns = 0, flip_seen = 0, degen_seen = 0;
  int cycle_count = 0;
  int in_gap = 0, out_gap = 0, long_hold = 0;
  bit hold_done = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch #%0d on %s: got %0d expected %0d", checked_faces, what, got, want);
    err_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Oriented unit face normal of one triangle, from the shadow store
  function automatic face_t face_normal(input vtx_txn_t t);
    face_t f;
    ofn_pkg::vertex_t v0, v1, v2;
    longint e1[3], e2[3], c[3], s[3];
    logic signed [127:0] dot;
    longint unsigned mag[3], m, nsq, r, u;
    int sh;
    v0 = shadow_store[t.ca];
    v1 = shadow_store[t.cb];
    v2 = shadow_store[t.cc];
    e1[0] = longint'(v1.px) - v0.px; e1[1] = longint'(v1.py) - v0.py;
    e1[2] = longint'(v1.pz) - v0.pz;
    e2[0] = longint'(v2.px) - v0.px; e2[1] = longint'(v2.py) - v0.py;
    e2[2] = longint'(v2.pz) - v0.pz;
    s[0] = longint'(v0.nx) + v1.nx + v2.nx;
    s[1] = longint'(v0.ny) + v1.ny + v2.ny;
    s[2] = longint'(v0.nz) + v1.nz + v2.nz;
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    // exact dot product at wide precision
    dot = 128'(signed'(c[0])) * 128'(signed'(s[0])) + 128'(signed'(c[1])) * 128'(signed'(s[1]))
        + 128'(signed'(c[2])) * 128'(signed'(s[2]));
    f.flip = dot < 0;
    if (f.flip) begin
      for (int i = 0; i < 3; i++) c[i] = -c[i];
    end
    f.degen = (c[0] == 0) && (c[1] == 0) && (c[2] == 0);
    f.last = t.last;
    f.fx = '0; f.fy = '0; f.fz = '0;
    if (!f.degen) begin
      m = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
        if (mag[i] > m) m = mag[i];
      end
      // common shift puts the largest magnitude in [2^29, 2^30)
      sh = 0;
      while (m >= (64'd1 << 30)) begin m >>= 1; sh++; end
      while (m < (64'd1 << 29)) begin m <<= 1; sh--; end
      nsq = 0;
      for (int i = 0; i < 3; i++) begin
        if (sh > 0) mag[i] >>= sh;
        else if (sh < 0) mag[i] <<= -sh;
        nsq += mag[i] * mag[i];
      end
      r = int_sqrt(nsq);
      for (int i = 0; i < 3; i++) begin
        u = ((mag[i] << 14) + (r >> 1)) / r;
        if (u > 16384) u = 16384;
        u = c[i] < 0 ? -u : u;
        if (i == 0) f.fx = u[15:0];
        else if (i == 1) f.fy = u[15:0];
        else f.fz = u[15:0];
      end
    end
    return f;
  endfunction

  // Applies one accepted transaction to the shadow store or the expectations
  task automatic accept_txn(input vtx_txn_t t);
    ofn_pkg::vertex_t v;
    sent_txns++;
    if (t.mode == MODE_LOAD) begin
      v.px = t.px; v.py = t.py; v.pz = t.pz;
      v.nx = t.nx; v.ny = t.ny; v.nz = t.nz;
      shadow_store[t.idx] = v;
    end else begin
      expected_faces.push_back(face_normal(t));
    end
  endtask

  // Generation helpers; slots are tracked so no unwritten entry is ever read
  function automatic vtx_txn_t rand_fill();
    vtx_txn_t t;
    t.mode = MODE_LOAD;
    t.idx = 12'($urandom); t.px = 24'($urandom); t.py = 24'($urandom);
    t.pz = 24'($urandom);
    t.nx = 16'(int'($urandom_range(32768)) - 16384);
    t.ny = 16'(int'($urandom_range(32768)) - 16384);
    t.nz = 16'(int'($urandom_range(32768)) - 16384);
    t.ca = 12'($urandom); t.cb = 12'($urandom); t.cc = 12'($urandom);
    t.last = 1'($urandom);
    return t;
  endfunction

  task automatic push_load(input int idx, input int x, input int y, input int z,
                           input int nx, input int ny, input int nz);
    vtx_txn_t t;
    t = rand_fill();
    t.idx = 12'(idx); t.px = 24'(x); t.py = 24'(y); t.pz = 24'(z);
    t.nx = 16'(nx); t.ny = 16'(ny); t.nz = 16'(nz);
    if (!slot_written[idx]) loaded_slots.push_back(idx);
    slot_written[idx] = 1'b1;
    pending_txns.push_back(t);
  endtask

  task automatic push_tri(input int a, input int b, input int c, input bit last);
    vtx_txn_t t;
    t = rand_fill();
    t.mode = MODE_TRI; t.ca = 12'(a); t.cb = 12'(b); t.cc = 12'(c); t.last = last;
    pending_txns.push_back(t);
  endtask

  function automatic int pick_slot();
    return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
  endfunction

  function automatic int rand_pos(input bit wide);
    int v;
    v = wide ? int'($urandom_range(16777215)) - 8388608 : int'($urandom_range(8191)) - 4096;
    return v;
  endfunction

  // Stimulus
  initial begin
    vtx_txn_t t;
    int a;
    // directed: extremes of positions and normals, slots 0 and 4095
    push_load(0, 0, 0, 0, 16384, 16384, 16384);
    push_load(4095, 8388607, 0, 0, -16384, -16384, -16384);
    push_load(1, 0, 8388607, 0, 0, 0, 16384);
    push_load(2, -8388608, -8388608, -8388608, 0, 0, 0);
    push_load(3, 0, 0, 8388607, 0, 0, 0);
    push_load(4, 4096, 4096, 4096, 0, 0, 0);
    push_tri(0, 4095, 1, 1'b0);   // normals agree: no flip
    push_tri(0, 1, 4095, 1'b1);   // reversed winding: flips
    push_tri(2, 4095, 1, 1'b0);   // largest spans, sum of normals mixed
    push_tri(2, 3, 4, 1'b1);      // normals sum to zero: no flip on zero dot
    push_tri(0, 0, 0, 1'b0);      // degenerate: repeated corner
    push_tri(0, 4, 2, 1'b1);      // degenerate: collinear points
    push_tri(4095, 2, 3, 1'b0);
    push_load(5, 1, 0, 0, 1, 1, 1);
    push_load(6, 0, 1, 0, 1, 1, 1);
    push_tri(0, 5, 6, 1'b1);      // tiny cross product, large upward shift
    // random: mostly well-formed meshes with some loads to far slots
    repeat (484) begin
      if ($urandom_range(99) < 35) begin
        t = rand_fill();
        a = $urandom_range(3) == 0 ? int'($urandom_range(4095)) : int'($urandom_range(31));
        push_load(a, rand_pos($urandom_range(3) == 0), rand_pos($urandom_range(3) == 0),
                  rand_pos($urandom_range(3) == 0), t.nx, t.ny, t.nz);
      end else if ($urandom_range(9) == 0) begin
        a = pick_slot();
        push_tri(a, pick_slot(), $urandom_range(1) ? a : pick_slot(), 1'($urandom));
      end else begin
        push_tri(pick_slot(), pick_slot(), pick_slot(), 1'($urandom));
      end
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_txns.size() == 0 && !in_valid && expected_faces.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d transactions, %0d faces checked (%0d flipped, %0d degenerate)",
             sent_txns, checked_faces, flip_seen, degen_seen);
    $display("stalls on both sides plus one long output hold");
    if (err_count == 0 && expected_faces.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver: next transaction goes out once the current one is taken
  always @(posedge clk) begin
    bit nxt_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) accept_txn(cur_txn);
      nxt_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_txns.size() > 0) begin
        cur_txn = pending_txns.pop_front();
        nxt_valid = 1'b1;
        mode <= cur_txn.mode; vertex_index <= cur_txn.idx;
        pos_x <= cur_txn.px; pos_y <= cur_txn.py; pos_z <= cur_txn.pz;
        vnorm_x <= cur_txn.nx; vnorm_y <= cur_txn.ny; vnorm_z <= cur_txn.nz;
        corner_a <= cur_txn.ca; corner_b <= cur_txn.cb; corner_c <= cur_txn.cc;
        last_in <= cur_txn.last;
        if (pending_txns.size() > 60 && $urandom_range(5) == 0) in_gap = $urandom_range(1, 3);
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor: compares each accepted face against the oldest expectation
  always @(posedge clk) begin
    face_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_faces.size() == 0) begin
        report_mismatch("unexpected face", 1, 0);
      end else begin
        want = expected_faces.pop_front();
        if (face_x !== want.fx) report_mismatch("face_x", face_x, want.fx);
        if (face_y !== want.fy) report_mismatch("face_y", face_y, want.fy);
        if (face_z !== want.fz) report_mismatch("face_z", face_z, want.fz);
        if (flipped !== want.flip) report_mismatch("flipped", flipped, want.flip);
        if (degenerate !== want.degen) report_mismatch("degenerate", degenerate, want.degen);
        if (last_out !== want.last) report_mismatch("last_out", last_out, want.last);
        flip_seen += want.flip;
        degen_seen += want.degen;
      end
      checked_faces++;
    end
  end

  // Receiver backpressure: short random bursts, one long hold to fill the core
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && sent_txns >= 150) begin
      hold_done <= 1'b1;
      long_hold <= 300;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (pending_txns.size() > 60 && $urandom_range(4) == 0) begin
      out_gap <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYC) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/ofn_pkg.sv
hdl/ofn_sqrt.sv
hdl/ofn_div.sv
hdl/oriented_face_normal_core.sv
hdl/ofn_checker.sv
bench/oriented_face_normal_core_tb.sv
